// ----- design/lcfc_pkg.sv -----
// Package for the link credit flow control block: request types, mode codes
// and sizes shared by all modules, and the credit arithmetic helpers used by the datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lcfc_pkg;

    localparam int LINK_COUNT = 4;
    localparam int CREDITS    = 16;

    localparam int MODE_W = 3;
    localparam int LINK_W = 2;
    localparam int CNT_W  = 8;

    localparam logic [CNT_W-1:0] CNT_MAX       = '1;
    localparam logic [CNT_W-1:0] CREDITS_RESET = CNT_W'(CREDITS);
    localparam logic [CNT_W-1:0] THRESH_RESET  = CNT_W'(12);

    localparam logic [MODE_W-1:0] MODE_SEND   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CREDIT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RECV   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FWD    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TICK   = 3'd4;

    typedef logic [LINK_W-1:0] t_link;
    typedef logic [CNT_W-1:0]  t_cnt;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        t_link             out_link;
        t_link             rx_link;
        t_cnt              rx_credit;
        logic              out_ready;
    } t_in_item;

    typedef struct packed {
        logic  sent;
        t_link link_used;
        t_cnt  credit_field;
        t_cnt  credits_left;
        logic  forced;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic commit;
    } t_dp_cmd;

    function automatic logic link_ok(input t_link idx);
        return ({1'b0, idx} < (LINK_W + 1)'(LINK_COUNT));
    endfunction

    function automatic logic may_send(input t_cnt avail, input t_cnt owed);
        return (avail > t_cnt'(1)) || ((avail == t_cnt'(1)) && (owed != '0));
    endfunction

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

    function automatic t_cnt sat_inc(input t_cnt a);
        return (a == CNT_MAX) ? a : a + t_cnt'(1);
    endfunction

endpackage

`default_nettype wire

// ----- design/lcfc_ctrl.sv -----
// Controller for the link credit flow control block: request sequencing and
// the output valid flag. Depends on lcfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcfc_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output lcfc_pkg::t_dp_cmd o_cmd
);
    import lcfc_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   slot_free;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        o_cmd.load   = 1'b0;
        o_cmd.commit = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |=> r_out_valid)
        else $error("committed request did not reach the output register");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.commit && r_out_valid && i_out_stall))
        else $error("result overwritten while the receiver stalls");

    a_exec_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EXEC && !slot_free) |=> (r_state == ST_EXEC))
        else $error("request left execution without a free output slot");

    a_load_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_EXEC && o_in_stall))
        else $error("accepted request did not enter execution");
`endif

endmodule

`default_nettype wire

// ----- design/lcfc_datapath.sv -----
// Datapath for the link credit flow control block: per-link credit counters,
// force flags, threshold register, request and result registers.
// Depends on lcfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lcfc_datapath (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  lcfc_pkg::t_dp_cmd   i_cmd,
    input  lcfc_pkg::t_in_item  i_in_item,
    input  wire                 i_cfg_we,
    input  lcfc_pkg::t_cnt      i_cfg_data,
    output lcfc_pkg::t_out_item o_out_item
);
    import lcfc_pkg::*;

    t_in_item  r_item;
    t_out_item r_out, n_out;
    t_cnt      r_thresh;
    t_cnt      r_avail [LINK_COUNT];
    t_cnt      n_avail [LINK_COUNT];
    t_cnt      r_owed  [LINK_COUNT];
    t_cnt      n_owed  [LINK_COUNT];
    logic [LINK_COUNT-1:0] r_force, n_force;

    t_link ol, rl, best;
    t_cnt  top;

    assign ol         = r_item.out_link;
    assign rl         = r_item.rx_link;
    assign o_out_item = r_out;

    always_comb begin
        best = '0;
        top  = '0;
        for (int i = 0; i < LINK_COUNT; i++) begin
            if (r_force[i] && (r_owed[i] > top)) begin
                best = LINK_W'(i);
                top  = r_owed[i];
            end
        end
    end

    always_comb begin
        n_avail = r_avail;
        n_owed  = r_owed;
        n_force = r_force;
        n_out   = '0;
        unique case (r_item.mode) inside
            MODE_SEND, MODE_FWD: begin
                n_out.link_used = ol;
                if (link_ok(ol)) begin
                    n_out.forced = r_force[ol];
                    if (r_item.out_ready && may_send(r_avail[ol], r_owed[ol])) begin
                        n_out.sent         = 1'b1;
                        n_out.credit_field = r_owed[ol];
                        n_avail[ol]        = r_avail[ol] - t_cnt'(1);
                        n_owed[ol]         = '0;
                        if ((r_item.mode == MODE_FWD) && link_ok(rl)) begin
                            n_avail[rl] = sat_add(n_avail[rl], r_item.rx_credit);
                            n_owed[rl]  = sat_inc(n_owed[rl]);
                        end
                    end
                    n_out.credits_left = n_avail[ol];
                end
            end
            MODE_CREDIT: begin
                n_out.link_used = best;
                n_out.forced    = r_force[best];
                if (r_force[best] && r_item.out_ready
                        && may_send(r_avail[best], r_owed[best])) begin
                    n_out.sent         = 1'b1;
                    n_out.credit_field = r_owed[best];
                    n_avail[best]      = r_avail[best] - t_cnt'(1);
                    n_owed[best]       = '0;
                end
                n_out.credits_left = n_avail[best];
            end
            MODE_RECV: begin
                n_out.link_used = rl;
                if (link_ok(rl)) begin
                    n_out.forced       = r_force[rl];
                    n_avail[rl]        = sat_add(r_avail[rl], r_item.rx_credit);
                    n_owed[rl]         = sat_inc(r_owed[rl]);
                    n_out.credits_left = n_avail[rl];
                end
            end
            MODE_TICK: begin
                for (int i = 0; i < LINK_COUNT; i++) begin
                    n_force[i] = (r_owed[i] >= r_thresh);
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_force  <= '0;
            for (int i = 0; i < LINK_COUNT; i++) begin
                r_avail[i] <= CREDITS_RESET;
                r_owed[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            if (i_cmd.commit) begin
                r_avail <= n_avail;
                r_owed  <= n_owed;
                r_force <= n_force;
            end
        end
    end

endmodule

`default_nettype wire

// ----- design/link_credit_flow_control.sv -----
// Top level of the link credit flow control block: controller and datapath.
// Depends on lcfc_pkg, lcfc_ctrl and lcfc_datapath.
//
// Each request names a mode (send, credit-only send, receive, forward or
// tick) and the links and credit count it concerns; each request yields
// exactly one result with the send decision, the link used, the owed count
// to piggyback, the credits left on that link and its prior force flag.
// The request channel uses i_in_valid with o_in_stall, the result channel
// o_out_valid with i_out_stall; a transfer happens when valid is high and
// stall is low. A request is held in the request register, then updates
// the per-link counters and loads the result register once the result
// slot is free; no new request is accepted before that. The result
// register frees the request side: the next request is taken while a
// result waits, and only its update waits until the held result is taken.
// The user must write the force threshold on the cfg channel (o_cfg_ready
// is always high) only while no request is in flight; the block does not
// enforce this.
// Reset restores every link to its full credit count, clears owed counts
// and force flags and sets the threshold back to its default.
`timescale 1ns / 1ps
`default_nettype none

module link_credit_flow_control (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  lcfc_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output lcfc_pkg::t_out_item o_out_item,
    input  wire                 i_cfg_valid,
    output logic                o_cfg_ready,
    input  lcfc_pkg::t_cnt      i_cfg_data
);
    import lcfc_pkg::*;

    t_dp_cmd cmd;

    assign o_cfg_ready = 1'b1;

    lcfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lcfc_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_item  (i_in_item),
        .i_cfg_we   (i_cfg_valid && o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .o_out_item (o_out_item)
    );

endmodule

`default_nettype wire
